### design/dpdc_pkg.sv
package dpdc_pkg;

  // Field widths of the two channels.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  // Offset year: year plus 400, so that year zero is handled by the same rule.
  localparam int YY_W = YEAR_W + 1;
  localparam logic [YY_W-1:0] YEAR_OFS = 15'd400;

  // Day number width (365 * 16783 plus leap and month terms stays below 2^23).
  localparam int DN_W = 23;

  // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT; exact for x below 43690.
  localparam logic [YY_W-1:0] RECIP_100   = 15'd20972;
  localparam int              RECIP_SHIFT = 21;
  localparam int              PROD_W      = 2 * YY_W;
  localparam int              Q100_W      = 8;
  localparam int              Q400_W      = Q100_W - 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 22'h3FFFFF;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_S  = 9'b000000010,
    S_LEAP_S = 9'b000000100,
    S_SUM_S  = 9'b000001000,
    S_MUL_E  = 9'b000010000,
    S_LEAP_E = 9'b000100000,
    S_SUM_E  = 9'b001000000,
    S_DIFF   = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic sel_end;
    logic do_mul;
    logic do_leap;
    logic do_sum;
    logic do_diff;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  // Length of a month; zero for a month outside January to December.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of the same year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
                                             input logic leap);
    logic [8:0] n;
    logic [8:0] lp;
    lp = {8'd0, leap};
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59 + lp;
      4'd4:    n = 9'd90 + lp;
      4'd5:    n = 9'd120 + lp;
      4'd6:    n = 9'd151 + lp;
      4'd7:    n = 9'd181 + lp;
      4'd8:    n = 9'd212 + lp;
      4'd9:    n = 9'd243 + lp;
      4'd10:   n = 9'd273 + lp;
      4'd11:   n = 9'd304 + lp;
      4'd12:   n = 9'd334 + lp;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### design/dpdc_ctrl.sv
module dpdc_ctrl
  import dpdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands: start date, then end date, then the difference.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_S;
        end
      end
      S_MUL_S: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_LEAP_S;
      end
      S_LEAP_S: begin
        cmd.do_leap = 1'b1;
        state_nxt   = S_SUM_S;
      end
      S_SUM_S: begin
        cmd.do_sum = 1'b1;
        state_nxt  = S_MUL_E;
      end
      S_MUL_E: begin
        cmd.sel_end = 1'b1;
        cmd.do_mul  = 1'b1;
        state_nxt   = S_LEAP_E;
      end
      S_LEAP_E: begin
        cmd.sel_end = 1'b1;
        cmd.do_leap = 1'b1;
        state_nxt   = S_SUM_E;
      end
      S_SUM_E: begin
        cmd.sel_end = 1'b1;
        cmd.do_sum  = 1'b1;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.do_diff = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### design/dpdc_dp.sv
module dpdc_dp
  import dpdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [DAY_W-1:0]   in_end_day,
  input  logic [MONTH_W-1:0] in_end_month,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic               in_include_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_day_count,
  output logic               out_bad_date
);

  // Captured request.
  logic [DAY_W-1:0]   sd_r, ed_r;
  logic [MONTH_W-1:0] sm_r, em_r;
  logic [YEAR_W-1:0]  sy_r, ey_r;
  logic               inc_r;

  // Working registers.
  logic [PROD_W-1:0]  prod_r;
  logic [YY_W-1:0]    yy_r;
  logic               leap_r;
  logic [Q100_W-1:0]  c100_r;
  logic [Q400_W-1:0]  c400_r;
  logic [DN_W-1:0]    yb_r;
  logic [DN_W-1:0]    a_r, b_r;
  logic               bad_r;
  logic [COUNT_W-1:0] cnt_r;

  // Output register.
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_day_count_r;
  logic               out_bad_date_r;

  logic [DAY_W-1:0]   cur_d;
  logic [MONTH_W-1:0] cur_m;
  logic [YEAR_W-1:0]  cur_y;
  logic [YY_W-1:0]    yy;
  logic [Q100_W-1:0]  f100;
  logic               div100, div4, div400, leap;
  logic [YY_W-1:0]    c4_sum;
  logic [DN_W-1:0]    yr365;
  logic [DAY_W-1:0]   len;
  logic               bad_now;
  logic [DN_W-1:0]    dn;
  logic [DN_W-1:0]    diff;
  logic [DN_W:0]      total;

  // Pick the date being worked on.
  assign cur_d = cmd.sel_end ? ed_r : sd_r;
  assign cur_m = cmd.sel_end ? em_r : sm_r;
  assign cur_y = cmd.sel_end ? ey_r : sy_r;
  assign yy    = YY_W'(cur_y) + YEAR_OFS;

  // Leap rule and the ceiling quotients by 4, 100 and 400 of the offset year.
  assign f100   = prod_r[RECIP_SHIFT +: Q100_W];
  assign div100 = ((YY_W'(f100) * YY_W'(100)) == yy_r);
  assign div4   = (yy_r[1:0] == 2'b00);
  assign div400 = div100 && (f100[1:0] == 2'b00);
  assign leap   = div4 && (!div100 || div400);
  assign c4_sum = yy_r + YY_W'(3);
  assign yr365  = DN_W'(yy_r) * DN_W'(365);

  // Day number of the date and its validity.
  assign len     = month_len(cur_m, leap_r);
  assign bad_now = (len == '0) || (cur_d == '0) || (cur_d > len);
  assign dn      = yb_r - DN_W'(c100_r) + DN_W'(c400_r)
                   + DN_W'(days_before(cur_m, leap_r)) + DN_W'(cur_d);

  // Distance, include flag and saturation.
  assign diff  = (a_r < b_r) ? (b_r - a_r) : '0;
  assign total = (DN_W+1)'(diff) + (DN_W+1)'(inc_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sd_r  <= in_start_day;
      sm_r  <= in_start_month;
      sy_r  <= in_start_year;
      ed_r  <= in_end_day;
      em_r  <= in_end_month;
      ey_r  <= in_end_year;
      inc_r <= in_include_end;
    end
    if (cmd.do_mul) begin
      prod_r <= PROD_W'(yy) * PROD_W'(RECIP_100);
      yy_r   <= yy;
    end
    if (cmd.do_leap) begin
      leap_r <= leap;
      c100_r <= f100 + Q100_W'(!div100);
      c400_r <= f100[Q100_W-1:2] + Q400_W'(!div400);
      yb_r   <= yr365 + DN_W'(c4_sum[YY_W-1:2]);
    end
    if (cmd.do_sum) begin
      if (cmd.sel_end) begin
        b_r   <= dn;
        bad_r <= bad_r | bad_now;
      end else begin
        a_r   <= dn;
        bad_r <= bad_now;
      end
    end
    if (cmd.do_diff) begin
      cnt_r <= (total[DN_W:COUNT_W] != '0) ? COUNT_MAX : total[COUNT_W-1:0];
    end
    if (cmd.load_out) begin
      out_day_count_r <= bad_r ? '0 : cnt_r;
      out_bad_date_r  <= bad_r;
    end
  end

  // Output valid: set on a new result, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_day_count = out_day_count_r;
  assign out_bad_date  = out_bad_date_r;

endmodule

### design/date_period_day_count_core.sv
// Day count between two Gregorian dates.
// A request on the in_ channel carries a start date, an end date and the
// include_end flag; it is taken at a clock edge where in_valid is high and
// in_stall is low. The result on the out_ channel is the number of days from
// start to end (zero when start is not before end), plus one when include_end
// is set, saturated to 22 bits. A day or month that is impossible sets
// out_bad_date and forces out_day_count to zero.
// Each date is turned into a day number in three steps on one datapath: a
// reciprocal multiply for the year divided by 100, the leap rule with the
// year terms, and the month and day sum. The start date, the end date and
// the final difference are worked out in turn, then the result is handed over
// to the output register and shown on out_valid; a new request is taken only
// once the controller is back in idle.
// in_stall is high while a request is in work. A finished result sits in the
// output register; the next request is accepted while it waits, and work on
// it stops before the hand-over until the receiver lowers out_stall.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; no request in work survives it.
module date_period_day_count_core
  import dpdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [MONTH_W-1:0] in_start_month,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [DAY_W-1:0]   in_end_day,
  input  logic [MONTH_W-1:0] in_end_month,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic               in_include_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_day_count,
  output logic               out_bad_date
);

  cmd_t cmd;
  sts_t sts;

  dpdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpdc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_end_day     (in_end_day),
    .in_end_month   (in_end_month),
    .in_end_year    (in_end_year),
    .in_include_end (in_include_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_day_count  (out_day_count),
    .out_bad_date   (out_bad_date)
  );

endmodule
